@@ rtl/assert_macros.svh @@
// Assertion shorthands shared by the RTL; all sample on clock, off while in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/sbcp_pkg.sv @@
package sbcp_pkg;

   // Reply ring; depth must be a power of two (wrap is by pointer overflow).
   localparam int RING_DEPTH  = 64;
   localparam int RING_AW     = $clog2(RING_DEPTH);
   localparam int ROW_AW      = RING_AW - 1;
   localparam int BANK_DEPTH  = RING_DEPTH / 2;
   localparam int FILL_W      = RING_AW + 1;

   localparam int CAPTURE_WORDS = 3;

   typedef enum logic [2:0] {
      MODE_WR_CMD  = 3'd0,
      MODE_RD_RSP  = 3'd1,
      MODE_RD_FLAG = 3'd2,
      MODE_WR_ECHO = 3'd3,
      MODE_RD_ECHO = 3'd4
   } mode_type;

   // Command opcodes
   localparam logic [15:0] OP_RESET_A  = 16'h5800;
   localparam logic [15:0] OP_RESET_B  = 16'h5A00;
   localparam logic [15:0] OP_QUERY_3A = 16'h003A;
   localparam logic [15:0] OP_QUERY_1B = 16'h001B;
   localparam logic [15:0] OP_QUERY_AA = 16'h00AA;
   localparam logic [15:0] OP_SUSPEND  = 16'h000E;
   localparam logic [15:0] OP_CAPTURE  = 16'hACE1;

   // Reply words
   localparam logic [15:0] RPL_RESET    = 16'h1000;
   localparam logic [15:0] RPL_ID_3A    = 16'hCC01;
   localparam logic [15:0] RPL_ID_1B    = 16'hCC09;
   localparam logic [15:0] RPL_ID_AA    = 16'hCC04;
   localparam logic [15:0] RPL_TEN      = 16'd10;
   localparam logic [15:0] RPL_CAPTURE  = 16'h0100;
   localparam logic [15:0] RPL_CAP_TAIL = 16'h000C;
   localparam logic [15:0] RPL_QRY_TAIL = 16'h0010;

   // Capture header decode
   localparam logic [7:0]  HDR_SHORT_MARK = 8'h55;
   localparam logic [15:0] HDR_QUERY_A    = 16'd999;
   localparam logic [15:0] HDR_QUERY_B    = 16'd1000;

   // Flag byte
   localparam logic [7:0] FLAG_BASE    = 8'h40;
   localparam logic [7:0] FLAG_PENDING = 8'h80;

   localparam logic [1:0] PUSH_NONE = 2'd0;
   localparam logic [1:0] PUSH_ONE  = 2'd1;
   localparam logic [1:0] PUSH_TWO  = 2'd2;

   typedef struct packed {
      logic        pop;
      logic [1:0]  push_cnt;
      logic [15:0] word0;
      logic [15:0] word1;
   } ring_cmd_type;

   typedef struct packed {
      logic        not_empty;
      logic [15:0] rd_data;
   } ring_stat_type;

endpackage

@@ rtl/sound_board_command_port_top.sv @@
// Sound-board command port. Each request is one bus access: req_tuser carries the access
// mode (write command, read response, read flag, write echo, read echo) and req_tdata the
// 16-bit word. Every request yields exactly one response. A request moves from the input
// register to the response register, which drives rsp_tvalid, once that register is free
// or leaving. The decode and a single access to the two-bank reply ring sit between the
// two registers, so one request per cycle is taken and sustained while rsp_tready stays
// high. Command writes may queue up to two reply words in the 64-entry ring (pushes onto
// a full ring are dropped); response reads pop the oldest word or return zero when the
// ring is empty. Opcode 0x0E toggles suspend, and 0xACE1 arms a header-plus-data capture
// that ends in a mixer event on rsp_tuser[0], or in two reply words for header 999/1000.
module sound_board_command_port_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // [15:0] data_word
   input  logic [2:0]  req_tuser,  // [2:0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,  // [15:0] read_data, [31:16] mixer_header,
                                   // [47:32] mixer_first, [63:48] mixer_second,
                                   // [79:64] sound_code
   output logic [1:0]  rsp_tuser   // [0] mixer_valid, [1] sound_valid
);
   import sbcp_pkg::*;

   `include "assert_macros.svh"

   // Input register
   logic        in_valid_ff;
   logic [2:0]  mode_ff;
   logic [15:0] word_ff;

   // Response register
   logic        out_valid_ff;
   logic        from_ring_ff, from_ring_in;
   logic [15:0] read_data_ff, read_data_in;
   logic        mixer_valid_ff, mixer_valid_in;
   logic [15:0] mixer_header_ff, mixer_header_in;
   logic [15:0] mixer_first_ff, mixer_first_in;
   logic [15:0] mixer_second_ff, mixer_second_in;
   logic        sound_valid_ff, sound_valid_in;
   logic [15:0] sound_code_ff, sound_code_in;

   // Port state
   logic [7:0]  echo_ff, echo_in;
   logic        suspended_ff, suspended_in;
   logic        armed_ff, armed_in;
   logic [1:0]  left_ff, left_in;
   logic [1:0]  held_ff, held_in;
   logic [15:0] cw_ff [CAPTURE_WORDS];
   logic [15:0] cw_in [CAPTURE_WORDS];

   // Capture working values
   logic [15:0] cw_next [CAPTURE_WORDS];
   logic [1:0]  held_next, left_next;

   logic          advance;
   ring_cmd_type  ring_cmd;
   ring_stat_type ring_stat;

   // A request moves from the input register when the response register is free or leaving.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         mode_ff <= req_tuser;
         word_ff <= req_tdata;
      end
   end

   always_comb begin
      echo_in      = echo_ff;
      suspended_in = suspended_ff;
      armed_in     = armed_ff;
      left_in      = left_ff;
      held_in      = held_ff;
      cw_in        = cw_ff;
      cw_next      = cw_ff;
      held_next    = held_ff;
      left_next    = left_ff;

      ring_cmd.pop      = 1'b0;
      ring_cmd.push_cnt = PUSH_NONE;
      ring_cmd.word0    = '0;
      ring_cmd.word1    = '0;

      from_ring_in    = 1'b0;
      read_data_in    = '0;
      mixer_valid_in  = 1'b0;
      mixer_header_in = '0;
      mixer_first_in  = '0;
      mixer_second_in = '0;
      sound_valid_in  = 1'b0;
      sound_code_in   = '0;

      unique case (mode_type'(mode_ff))
         MODE_WR_CMD: begin
            if (suspended_ff) begin
               // only the suspend opcode is heard; it resumes and acks
               if (word_ff == OP_SUSPEND) begin
                  suspended_in      = 1'b0;
                  armed_in          = 1'b0;
                  left_in           = '0;
                  held_in           = '0;
                  ring_cmd.push_cnt = PUSH_ONE;
                  ring_cmd.word0    = RPL_TEN;
               end
            end else if (armed_ff) begin
               if (left_ff == '0) begin
                  // header word: short capture when the high byte is the marker
                  left_in  = (word_ff[15:8] == HDR_SHORT_MARK) ? 2'd1 : 2'd2;
                  cw_in[0] = word_ff;
                  held_in  = 2'd1;
               end else begin
                  if (held_ff != 2'd3) begin
                     cw_next[held_ff] = word_ff;
                     held_next        = held_ff + 2'd1;
                  end
                  left_next = left_ff - 2'd1;
                  if (left_next != '0) begin
                     cw_in   = cw_next;
                     held_in = held_next;
                     left_in = left_next;
                  end else begin
                     if (cw_next[0] == HDR_QUERY_A || cw_next[0] == HDR_QUERY_B) begin
                        ring_cmd.push_cnt = PUSH_TWO;
                        ring_cmd.word0    = RPL_CAPTURE;
                        ring_cmd.word1    = RPL_QRY_TAIL;
                     end else begin
                        mixer_valid_in  = 1'b1;
                        mixer_header_in = cw_next[0];
                        mixer_first_in  = (held_next > 2'd1) ? cw_next[1] : '0;
                        mixer_second_in = (held_next > 2'd2) ? cw_next[2] : '0;
                     end
                     left_in = '0;
                     held_in = '0;
                     for (int i = 0; i < CAPTURE_WORDS; i++) begin
                        cw_in[i] = '0;
                     end
                  end
               end
            end else begin
               unique case (word_ff)
                  OP_RESET_A, OP_RESET_B: begin
                     ring_cmd.push_cnt = PUSH_ONE;
                     ring_cmd.word0    = RPL_RESET;
                  end
                  OP_QUERY_3A: begin
                     ring_cmd.push_cnt = PUSH_TWO;
                     ring_cmd.word0    = RPL_ID_3A;
                     ring_cmd.word1    = RPL_TEN;
                     sound_valid_in    = 1'b1;
                     sound_code_in     = word_ff;
                  end
                  OP_QUERY_1B: begin
                     ring_cmd.push_cnt = PUSH_TWO;
                     ring_cmd.word0    = RPL_ID_1B;
                     ring_cmd.word1    = RPL_TEN;
                  end
                  OP_QUERY_AA: begin
                     ring_cmd.push_cnt = PUSH_TWO;
                     ring_cmd.word0    = RPL_ID_AA;
                     ring_cmd.word1    = RPL_TEN;
                     sound_valid_in    = 1'b1;
                     sound_code_in     = word_ff;
                  end
                  OP_SUSPEND: begin
                     suspended_in = 1'b1;
                     armed_in     = 1'b0;
                  end
                  OP_CAPTURE: begin
                     armed_in          = 1'b1;
                     ring_cmd.push_cnt = PUSH_TWO;
                     ring_cmd.word0    = RPL_CAPTURE;
                     ring_cmd.word1    = RPL_CAP_TAIL;
                  end
                  default: begin
                     // anything else is a direct sound trigger
                     sound_valid_in = 1'b1;
                     sound_code_in  = word_ff;
                  end
               endcase
            end
         end
         MODE_RD_RSP: begin
            ring_cmd.pop = 1'b1;
            from_ring_in = ring_stat.not_empty;   // empty ring reads as zero
         end
         MODE_RD_FLAG: begin
            read_data_in = {8'h00, FLAG_BASE | (ring_stat.not_empty ? FLAG_PENDING : 8'h00)};
         end
         MODE_WR_ECHO: begin
            echo_in = word_ff[7:0];
         end
         MODE_RD_ECHO: begin
            read_data_in = {8'h00, echo_ff};
         end
         default: begin
            // unused modes: no effect, all-zero response
         end
      endcase
   end

   sbcp_ring u_ring (
      .clock (clock),
      .reset (reset),
      .en    (advance),
      .cmd   (ring_cmd),
      .stat  (ring_stat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         echo_ff      <= '0;
         suspended_ff <= 1'b0;
         armed_ff     <= 1'b0;
         left_ff      <= '0;
         held_ff      <= '0;
         for (int i = 0; i < CAPTURE_WORDS; i++) begin
            cw_ff[i] <= '0;
         end
      end else if (advance) begin
         echo_ff      <= echo_in;
         suspended_ff <= suspended_in;
         armed_ff     <= armed_in;
         left_ff      <= left_in;
         held_ff      <= held_in;
         cw_ff        <= cw_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         from_ring_ff    <= from_ring_in;
         read_data_ff    <= read_data_in;
         mixer_valid_ff  <= mixer_valid_in;
         mixer_header_ff <= mixer_header_in;
         mixer_first_ff  <= mixer_first_in;
         mixer_second_ff <= mixer_second_in;
         sound_valid_ff  <= sound_valid_in;
         sound_code_ff   <= sound_code_in;
      end
   end

   // The popped word comes straight from the ring's read register.
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {sound_code_ff, mixer_second_ff, mixer_first_ff, mixer_header_ff,
                        (from_ring_ff ? ring_stat.rd_data : read_data_ff)};
   assign rsp_tuser  = {sound_valid_ff, mixer_valid_ff};

   `ASSERT_IMPLIES(a_susp_idle, suspended_ff, !armed_ff && left_ff == '0 && held_ff == '0,
                   "capture state live while suspended")
   `ASSERT_IMPLIES(a_one_event, rsp_tvalid, !(mixer_valid_ff && sound_valid_ff),
                   "mixer event and sound trigger in one response")
   `ASSERT_IMPLIES(a_idle_capture, !armed_ff, left_ff == '0 && held_ff == '0,
                   "capture counters live while disarmed")

endmodule

@@ rtl/sbcp_ring.sv @@
// Reply ring: two banks (even / odd slots) so a request can push two words in one cycle.
module sbcp_ring (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  sbcp_pkg::ring_cmd_type cmd,
   output sbcp_pkg::ring_stat_type stat
);
   import sbcp_pkg::*;

   `include "assert_macros.svh"

   localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(RING_DEPTH);
   localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(RING_DEPTH - 1);

   logic [15:0] bank0 [BANK_DEPTH];
   logic [15:0] bank1 [BANK_DEPTH];

   logic [RING_AW-1:0] head_ff, head_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [15:0]        rd0_ff, rd1_ff;
   logic               sel_ff;

   logic [RING_AW-1:0] tail, tail1;
   logic               ok0, ok1, do_pop;
   logic               we0, we1;
   logic [ROW_AW-1:0]  addr0, addr1;
   logic [15:0]        wd0, wd1;

   always_comb begin
      tail   = head_ff + fill_ff[RING_AW-1:0];
      tail1  = tail + RING_AW'(1);
      ok0    = (cmd.push_cnt != PUSH_NONE) && (fill_ff != FILL_FULL);
      ok1    = (cmd.push_cnt == PUSH_TWO) && (fill_ff < FILL_LAST);
      do_pop = cmd.pop && (fill_ff != '0);

      if (!tail[0]) begin
         we0 = ok0; addr0 = tail[RING_AW-1:1];  wd0 = cmd.word0;
         we1 = ok1; addr1 = tail1[RING_AW-1:1]; wd1 = cmd.word1;
      end else begin
         we1 = ok0; addr1 = tail[RING_AW-1:1];  wd1 = cmd.word0;
         we0 = ok1; addr0 = tail1[RING_AW-1:1]; wd0 = cmd.word1;
      end

      fill_in = fill_ff + FILL_W'(ok0) + FILL_W'(ok1) - FILL_W'(do_pop);
      head_in = do_pop ? head_ff + RING_AW'(1) : head_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         fill_ff <= '0;
      end else if (en) begin
         head_ff <= head_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en && we0) begin
         bank0[addr0] <= wd0;
      end
      if (en && we1) begin
         bank1[addr1] <= wd1;
      end
   end

   // Registered read at the head; the bank pick follows the head's low bit.
   always_ff @(posedge clock) begin
      if (en && cmd.pop) begin
         rd0_ff <= bank0[head_ff[RING_AW-1:1]];
         rd1_ff <= bank1[head_ff[RING_AW-1:1]];
         sel_ff <= head_ff[0];
      end
   end

   assign stat.not_empty = (fill_ff != '0);
   assign stat.rd_data   = sel_ff ? rd1_ff : rd0_ff;

   `ASSERT_IMPLIES(a_fill_bound, 1'b1, fill_ff <= FILL_FULL, "ring fill beyond depth")
   `ASSERT_NEXT(a_empty_pop, en && cmd.pop && fill_ff == '0, fill_ff == '0 && $stable(head_ff),
                "pop of empty ring moved pointers")
   `ASSERT_NEXT(a_full_drop, en && !cmd.pop && fill_ff == FILL_FULL, fill_ff == FILL_FULL,
                "push onto full ring changed fill")

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
   import sbcp_pkg::*;

   localparam int PHASE_A_ITEMS = 900;   // command decode, suspend, ring full/empty
   localparam int TOTAL_ITEMS   = 1800;  // then capture mode for the rest of the run
   localparam int TAIL_ITEMS    = 200;   // last stretch runs with no idling
   localparam int QUIET_LIMIT   = 500;   // cycles with no handshake on either side
   localparam int MAX_PRINTED   = 50;

   typedef struct packed {
      logic [2:0]  mode;
      logic [15:0] word;
   } bus_access_type;

   typedef struct packed {
      logic [15:0] read_data;
      logic        mixer_valid;
      logic [15:0] mixer_header;
      logic [15:0] mixer_first;
      logic [15:0] mixer_second;
      logic        sound_valid;
      logic [15:0] sound_code;
   } port_response_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;  // [15:0] data_word
   logic [2:0]  req_tuser = '0;  // [2:0] mode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;       // [15:0] read_data, [31:16] mixer_header,
                                 // [47:32] mixer_first, [63:48] mixer_second,
                                 // [79:64] sound_code
   logic [1:0]  rsp_tuser;       // [0] mixer_valid, [1] sound_valid

   sound_board_command_port_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Pending requests and the responses they should produce.
   bus_access_type    access_queue[$];
   port_response_type awaited_responses[$];

   // Shadow of the port state, advanced once per accepted request.
   logic [15:0]         ring_mem [RING_DEPTH];
   logic [RING_AW-1:0]  ring_rd      = '0;
   logic [FILL_W-1:0]   ring_count   = '0;
   logic [7:0]          echo_reg     = '0;
   logic                suspended_q  = 1'b0;
   logic                armed_q      = 1'b0;
   logic [1:0]          left_q       = '0;
   logic [1:0]          held_q       = '0;
   logic [15:0]         capture_q [CAPTURE_WORDS] = '{default: '0};

   // Generator's view of the port, used to shape sequences and count requests.
   bit gen_suspended = 1'b0;
   bit gen_armed     = 1'b0;
   int gen_left      = 0;
   int planned_items = 0;

   int mismatch_count  = 0;
   int sent_count      = 0;
   int received_count  = 0;
   int mixer_events    = 0;
   int sound_triggers  = 0;
   int dropped_pushes  = 0;
   int empty_pops      = 0;
   int ignored_cmds    = 0;
   int send_gap        = 0;
   int send_idle_pct   = 0;
   int stall_left      = 0;
   int stall_pct       = 0;
   int quiet_cycles    = 0;

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      if (mismatch_count < MAX_PRINTED)
         $display("mismatch at response %0d: %s got %h expected %h",
                  received_count, what, got, want);
      mismatch_count++;
   endtask

   task automatic ring_push(input logic [15:0] value);
      logic [RING_AW-1:0] slot;
      if (ring_count < RING_DEPTH) begin
         slot = ring_rd + ring_count[RING_AW-1:0];
         ring_mem[slot] = value;
         ring_count++;
      end else begin
         dropped_pushes++;
      end
   endtask

   // Advance the shadow state by one bus access and queue the response it yields.
   task automatic decode_access(input logic [2:0] mode, input logic [15:0] word);
      port_response_type res;
      res = '0;
      case (mode)
         MODE_WR_CMD: begin
            if (suspended_q) begin
               // only the suspend opcode is honoured; it resumes and acks
               if (word == OP_SUSPEND) begin
                  suspended_q = 1'b0;
                  armed_q     = 1'b0;
                  left_q      = '0;
                  held_q      = '0;
                  ring_push(RPL_TEN);
               end else begin
                  ignored_cmds++;
               end
            end else if (armed_q) begin
               // every word is capture data, opcodes included
               if (left_q == 0) begin
                  left_q       = (word[15:8] == HDR_SHORT_MARK) ? 2'd1 : 2'd2;
                  capture_q[0] = word;
                  held_q       = 2'd1;
               end else begin
                  if (held_q < CAPTURE_WORDS) begin
                     capture_q[held_q] = word;
                     held_q++;
                  end
                  left_q--;
                  if (left_q == 0) begin
                     if (capture_q[0] == HDR_QUERY_A || capture_q[0] == HDR_QUERY_B) begin
                        ring_push(RPL_CAPTURE);
                        ring_push(RPL_QRY_TAIL);
                     end else begin
                        res.mixer_valid  = 1'b1;
                        res.mixer_header = capture_q[0];
                        res.mixer_first  = (held_q > 1) ? capture_q[1] : 16'h0000;
                        res.mixer_second = (held_q > 2) ? capture_q[2] : 16'h0000;
                        mixer_events++;
                     end
                     held_q    = '0;
                     capture_q = '{default: '0};
                  end
               end
            end else begin
               case (word)
                  OP_RESET_A, OP_RESET_B: ring_push(RPL_RESET);
                  OP_QUERY_3A: begin
                     ring_push(RPL_ID_3A);
                     ring_push(RPL_TEN);
                     res.sound_valid = 1'b1;
                     res.sound_code  = word;
                  end
                  OP_QUERY_1B: begin
                     ring_push(RPL_ID_1B);
                     ring_push(RPL_TEN);
                  end
                  OP_QUERY_AA: begin
                     ring_push(RPL_ID_AA);
                     ring_push(RPL_TEN);
                     res.sound_valid = 1'b1;
                     res.sound_code  = word;
                  end
                  OP_SUSPEND: begin
                     suspended_q = 1'b1;
                     armed_q     = 1'b0;
                  end
                  OP_CAPTURE: begin
                     armed_q = 1'b1;
                     ring_push(RPL_CAPTURE);
                     ring_push(RPL_CAP_TAIL);
                  end
                  default: begin
                     res.sound_valid = 1'b1;
                     res.sound_code  = word;
                  end
               endcase
               if (res.sound_valid) sound_triggers++;
            end
         end
         MODE_RD_RSP: begin
            if (ring_count != 0) begin
               res.read_data = ring_mem[ring_rd];
               ring_rd++;
               ring_count--;
            end else begin
               empty_pops++;
            end
         end
         MODE_RD_FLAG:
            res.read_data = {8'h00, (ring_count != 0) ? (FLAG_BASE | FLAG_PENDING) : FLAG_BASE};
         MODE_WR_ECHO: echo_reg = word[7:0];
         MODE_RD_ECHO: res.read_data = {8'h00, echo_reg};
         default: ;  // unused modes: no effect, all-zero response
      endcase
      awaited_responses.push_back(res);
   endtask

   // Queue one request and keep the generator's view of the port up to date.
   task automatic queue_access(input logic [2:0] mode, input logic [15:0] word);
      if (mode == MODE_WR_CMD) begin
         if (gen_suspended) begin
            if (word == OP_SUSPEND) gen_suspended = 1'b0;
         end else if (gen_armed) begin
            if (gen_left == 0) gen_left = (word[15:8] == HDR_SHORT_MARK) ? 1 : 2;
            else gen_left--;
         end else if (word == OP_SUSPEND) begin
            gen_suspended = 1'b1;
         end else if (word == OP_CAPTURE) begin
            gen_armed = 1'b1;
         end
      end
      planned_items++;
      access_queue.push_back('{mode: mode, word: word});
   endtask

   // Anything but a command write: reads, echo traffic and the unused modes.
   task automatic queue_side_access();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 4)
         queue_access(MODE_RD_RSP, 16'($urandom));
      else if (pick < 6)
         queue_access(MODE_RD_FLAG, 16'($urandom));
      else if (pick < 8)
         queue_access(MODE_WR_ECHO, 16'($urandom));
      else if (pick < 9)
         queue_access(MODE_RD_ECHO, 16'($urandom));
      else
         queue_access(3'(MODE_RD_ECHO) + 3'($urandom_range(1, 3)), 16'($urandom));
   endtask

   // Driver: presents queued requests, holding each until accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= '0;
         send_gap   = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            decode_access(req_tuser, req_tdata);
            sent_count++;
            if (sent_count % 64 == 0) send_idle_pct = 8 * $urandom_range(0, 3);
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap != 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (access_queue.size() == 0) begin
               req_tvalid <= 1'b0;
            end else if (access_queue.size() > TAIL_ITEMS &&
                         $urandom_range(1, 100) <= send_idle_pct) begin
               send_gap = $urandom_range(0, 9);
               req_tvalid <= 1'b0;
            end else begin
               req_tuser  <= access_queue[0].mode;
               req_tdata  <= access_queue[0].word;
               req_tvalid <= 1'b1;
               void'(access_queue.pop_front());
            end
         end
      end
   end

   // Monitor: checks each response against the oldest awaited one, stalls at random.
   always @(posedge clock) begin
      port_response_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_responses.size() == 0) begin
               report_mismatch("response with nothing awaited", rsp_tdata[15:0], 16'h0000);
            end else begin
               want = awaited_responses.pop_front();
               if (rsp_tdata[15:0] !== want.read_data)
                  report_mismatch("read_data", rsp_tdata[15:0], want.read_data);
               if (rsp_tuser[0] !== want.mixer_valid)
                  report_mismatch("mixer_valid", 16'(rsp_tuser[0]), 16'(want.mixer_valid));
               if (rsp_tdata[31:16] !== want.mixer_header)
                  report_mismatch("mixer_header", rsp_tdata[31:16], want.mixer_header);
               if (rsp_tdata[47:32] !== want.mixer_first)
                  report_mismatch("mixer_first", rsp_tdata[47:32], want.mixer_first);
               if (rsp_tdata[63:48] !== want.mixer_second)
                  report_mismatch("mixer_second", rsp_tdata[63:48], want.mixer_second);
               if (rsp_tuser[1] !== want.sound_valid)
                  report_mismatch("sound_valid", 16'(rsp_tuser[1]), 16'(want.sound_valid));
               if (rsp_tdata[79:64] !== want.sound_code)
                  report_mismatch("sound_code", rsp_tdata[79:64], want.sound_code);
            end
            received_count++;
            if (received_count % 64 == 0) stall_pct = 8 * $urandom_range(0, 3);
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (access_queue.size() > TAIL_ITEMS &&
                      $urandom_range(1, 100) <= stall_pct) begin
            stall_left = $urandom_range(0, 9);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: ends the run if neither side hands anything over for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int          pick;
      logic [15:0] word;

      // Directed: empty ring, reset flag/echo, non-capture opcodes, suspend round trip.
      queue_access(MODE_RD_RSP,  16'h0000);
      queue_access(MODE_RD_FLAG, 16'h0000);
      queue_access(MODE_RD_ECHO, 16'h0000);
      queue_access(MODE_WR_ECHO, 16'hFFFF);
      queue_access(MODE_RD_ECHO, 16'h0000);
      queue_access(MODE_WR_CMD,  OP_RESET_A);
      queue_access(MODE_WR_CMD,  OP_RESET_B);
      queue_access(MODE_WR_CMD,  OP_QUERY_3A);
      queue_access(MODE_WR_CMD,  OP_QUERY_1B);
      queue_access(MODE_WR_CMD,  OP_QUERY_AA);
      queue_access(MODE_WR_CMD,  16'hFFFF);
      queue_access(MODE_WR_CMD,  OP_SUSPEND);
      queue_access(MODE_WR_CMD,  OP_QUERY_3A);   // dropped while suspended
      queue_access(MODE_WR_CMD,  OP_SUSPEND);    // resume, acks with ten
      queue_access(3'b111,       16'hFFFF);

      // Random decode traffic; capture is never armed here, as arming is for good.
      while (planned_items < PHASE_A_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            case ($urandom_range(0, 15))
               0: word = OP_RESET_A;
               1: word = OP_RESET_B;
               2, 3: word = OP_QUERY_3A;
               4: word = OP_QUERY_1B;
               5: word = OP_QUERY_AA;
               6: word = OP_SUSPEND;
               default: begin
                  word = 16'($urandom);
                  if (word == OP_CAPTURE) word = OP_RESET_A;
               end
            endcase
            queue_access(MODE_WR_CMD, word);
         end else if (pick < 94) begin
            queue_side_access();
         end else if (pick < 97) begin
            // flood of two-word replies to run the ring into its full state
            repeat ($urandom_range(20, 40)) begin
               case ($urandom_range(0, 2))
                  0: queue_access(MODE_WR_CMD, OP_QUERY_3A);
                  1: queue_access(MODE_WR_CMD, OP_QUERY_1B);
                  default: queue_access(MODE_WR_CMD, OP_QUERY_AA);
               endcase
            end
         end else begin
            repeat ($urandom_range(10, 70)) queue_access(MODE_RD_RSP, 16'($urandom));
         end
      end
      if (gen_suspended) queue_access(MODE_WR_CMD, OP_SUSPEND);

      // Directed capture: arm, short header, both query headers, opcodes as data.
      queue_access(MODE_WR_CMD, OP_CAPTURE);
      queue_access(MODE_WR_CMD, {HDR_SHORT_MARK, 8'hFF});
      queue_access(MODE_WR_CMD, 16'h0000);
      queue_access(MODE_WR_CMD, HDR_QUERY_A);
      queue_access(MODE_WR_CMD, 16'h1234);
      queue_access(MODE_WR_CMD, 16'hFFFF);
      queue_access(MODE_WR_CMD, HDR_QUERY_B);
      queue_access(MODE_WR_CMD, 16'h0000);
      queue_access(MODE_WR_CMD, 16'h8001);
      queue_access(MODE_WR_CMD, OP_SUSPEND);
      queue_access(MODE_WR_CMD, OP_CAPTURE);
      queue_access(MODE_WR_CMD, OP_SUSPEND);

      // Random captures, mostly whole triples with reads mixed in between words.
      while (planned_items < TOTAL_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            if (gen_left == 0) begin
               case ($urandom_range(0, 9))
                  0, 1, 2: word = {HDR_SHORT_MARK, 8'($urandom)};
                  3: word = HDR_QUERY_A;
                  4: word = HDR_QUERY_B;
                  5: word = OP_SUSPEND;
                  6: word = OP_CAPTURE;
                  default: word = 16'($urandom);
               endcase
               queue_access(MODE_WR_CMD, word);
            end
            while (gen_left != 0) begin
               if ($urandom_range(0, 9) < 3) queue_side_access();
               case ($urandom_range(0, 9))
                  0: word = OP_SUSPEND;
                  1: word = OP_CAPTURE;
                  default: word = 16'($urandom);
               endcase
               queue_access(MODE_WR_CMD, word);
            end
         end else if (pick < 60) begin
            queue_access(MODE_WR_CMD, 16'($urandom));   // breaks the framing
         end else if (pick < 97) begin
            queue_side_access();
         end else begin
            repeat ($urandom_range(10, 40)) queue_access(MODE_RD_RSP, 16'($urandom));
         end
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (access_queue.size() != 0 || req_tvalid || awaited_responses.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      if (awaited_responses.size() != 0)
         report_mismatch("responses never delivered",
                         16'(awaited_responses.size()), 16'h0000);

      $display("%0d requests, %0d responses: %0d mixer events, %0d sound triggers",
               sent_count, received_count, mixer_events, sound_triggers);
      $display("%0d replies dropped on a full ring, %0d empty-ring reads, %0d commands %s",
               dropped_pushes, empty_pops, ignored_cmds, "ignored while suspended");
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

@@ sound_board_command_port_top.f @@
+incdir+rtl
rtl/sbcp_pkg.sv
rtl/sbcp_ring.sv
rtl/sound_board_command_port_top.sv
sim/testbench.sv
